// ===== src/afps_pkg.sv =====
`timescale 1ns / 1ps

package afps_pkg;

	localparam int FFT_N    = 1024;
	localparam int LOG2N    = $clog2(FFT_N);
	localparam int HALF_N   = FFT_N / 2;
	localparam int FFT_N_M1 = FFT_N - 1;
	localparam int STG_W    = $clog2(LOG2N);

	typedef logic [LOG2N-1:0] addr_t;
	typedef logic [LOG2N-2:0] bfly_t;
	typedef logic [STG_W-1:0] stage_t;

	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_COMPUTE = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	localparam logic signed [15:0] DB_FLOOR = -16'sd25600;
	localparam logic [8:0]         WT_RESET = 9'd77;
	localparam logic [8:0]         WT_FULL  = 9'd256;

	localparam logic [63:0]        HALF_PI_Q30     = 64'd1686629713;
	localparam logic signed [26:0] TEN_LOG10_2_Q24 = 27'sd50504453;
	// log2 offset of full scale: 2*(14 + log2 N), in 16 fraction bits
	localparam logic signed [22:0] LG_OFFSET = 23'((2 * (14 + LOG2N)) << 16);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_BF_RD,
		ST_BF_MUL,
		ST_BF_SUM,
		ST_BF_WU,
		ST_BF_WV,
		ST_DB_RD,
		ST_DB_SQ,
		ST_DB_SUM,
		ST_DB_NORM,
		ST_DB_LOG,
		ST_DB_SCALE,
		ST_DB_RND,
		ST_DB_MIX,
		ST_DB_WR
	} state_t;

	typedef struct packed {
		logic signed [63:0] c;
		logic signed [63:0] s;
	} cs_t;

	typedef logic [16:0]        win_rom_t [FFT_N];
	typedef logic signed [31:0] tw_rom_t  [HALF_N];

	// sin of r/2^30 quarter turns, Q30, Taylor series to eight terms
	function automatic logic [63:0] sin_quarter(input logic [31:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] t;
		logic signed [63:0] sum;
		x    = ({32'd0, r} * HALF_PI_Q30) >> 30;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		for (int k = 1; k <= 7; k++) begin
			t = (term * x2) >> 30;
			unique case (k)
				1: term = t / 64'd6;
				2: term = t / 64'd20;
				3: term = t / 64'd42;
				4: term = t / 64'd72;
				5: term = t / 64'd110;
				6: term = t / 64'd156;
				default: term = t / 64'd210;
			endcase
			if (k[0]) sum = sum - $signed(term);
			else sum = sum + $signed(term);
		end
		if (sum < 0) sum = '0;
		if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
		return sum;
	endfunction

	// cos and sin of phase p (full turn = 2^32), Q30
	function automatic cs_t turn_cs(input logic [31:0] p);
		logic [31:0] r;
		logic signed [63:0] a;
		logic signed [63:0] b;
		cs_t res;
		r = p & 32'h3FFF_FFFF;
		a = $signed(sin_quarter(r));
		b = $signed(sin_quarter(32'h4000_0000 - r));
		unique case (p[31:30])
			2'd0: begin res.s = a;  res.c = b;  end
			2'd1: begin res.s = b;  res.c = -a; end
			2'd2: begin res.s = -a; res.c = -b; end
			default: begin res.s = -b; res.c = a; end
		endcase
		return res;
	endfunction

	function automatic win_rom_t build_win();
		win_rom_t rom;
		logic [31:0] p;
		cs_t cs;
		logic signed [63:0] w;
		for (int n = 0; n < FFT_N; n++) begin
			p = 32'((64'(n) << 32) / FFT_N_M1);
			cs = turn_cs(p);
			w = ((64'sd1 <<< 30) - cs.c + (64'sd1 <<< 15)) >>> 16;
			rom[n] = 17'(w);
		end
		return rom;
	endfunction

	function automatic tw_rom_t build_tw(input logic want_sin);
		tw_rom_t rom;
		logic [31:0] p;
		cs_t cs;
		for (int n = 0; n < HALF_N; n++) begin
			p = 32'((64'(n) << 32) >> LOG2N);
			cs = turn_cs(p);
			rom[n] = want_sin ? 32'(cs.s) : 32'(cs.c);
		end
		return rom;
	endfunction

	localparam win_rom_t WIN_ROM = build_win();
	localparam tw_rom_t  TW_COS  = build_tw(1'b0);
	localparam tw_rom_t  TW_SIN  = build_tw(1'b1);

	function automatic addr_t bit_rev(input addr_t v);
		addr_t r;
		for (int b = 0; b < LOG2N; b++) r[b] = v[LOG2N-1-b];
		return r;
	endfunction

	// shift right by s, rounding half away from zero
	function automatic logic signed [65:0] round_shift(input logic signed [65:0] v,
			input int s);
		logic [65:0] m;
		m = v[65] ? 66'(-v) : 66'(v);
		m = (m + (66'd1 << (s - 1))) >> s;
		return v[65] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -36'sd2147483648) return 32'sh8000_0000;
		return 32'(v);
	endfunction

endpackage

// ===== src/afps_if.sv =====
`timescale 1ns / 1ps

interface afps_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [15:0] sample_i;
	logic signed [15:0] sample_q;
	logic [9:0]         bin_index;

	modport source (output valid, opcode, sample_i, sample_q, bin_index, input ready);
	modport sink   (input valid, opcode, sample_i, sample_q, bin_index, output ready);
endinterface

interface afps_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] bin_db;

	modport source (output valid, bin_db, input ready);
	modport sink   (input valid, bin_db, output ready);
endinterface

// ===== src/averaged_fft_power_spectrum.sv =====
`timescale 1ns / 1ps

// channel  dir  payload                                    accepted when
// req      in   opcode, sample_i, sample_q, bin_index      req.valid & req.ready
// rsp      out  bin_db (Q7.8 dB)                           rsp.valid & rsp.ready
// cfg      in   cfg_wdata = avg_new_weight (Q1.8)          cfg_we
//
// Push: one request per cycle while ready, written straight into the sample ring.
// Read: the memory is read into a register as the request is accepted; the result
//   moves to the output register and rsp.valid once that register is not stalled.
// Compute: a windowed load of the ring, 10 x 512 butterflies, then a dB pass per
//   bin; the butterflies share one datapath and the single work memory.
// Reset: no clearing pass; a fill count masks unwritten ring entries and the
//   spectrum reads -100 dB until the first compute completes.
// A stalled result holds off every request (push included) once a second read is
//   queued behind it.

module averaged_fft_power_spectrum
	import afps_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	afps_req_if.sink       req,
	afps_rsp_if.source     rsp,
	input  logic           cfg_we,
	input  logic [8:0]     cfg_wdata
);

	// ---------------- control state ----------------
	state_t state_q, state_d;

	logic [8:0]     wt_q;
	addr_t          wp_q;
	logic [LOG2N:0] fill_q;      // pushes so far, saturating at N
	logic           started_q;

	logic           rd_pend_s1;
	logic           rsp_v_q;
	logic [15:0]    rsp_q;

	logic [LOG2N:0] ld_n_q;      // load issue counter, top bit = done
	logic           ld_v_s1, ld_v_s2;
	logic           ld_ok_s1;
	addr_t          ld_n_s1, ld_n_s2;

	stage_t         stage_q;
	bfly_t          bfly_q;
	addr_t          bin_q;
	logic [2:0]     nrm_q;
	logic [3:0]     lbit_q;

	logic req_acc, out_blocked;
	assign req_acc     = req.valid && req.ready;
	assign out_blocked = rsp_v_q && !rsp.ready;
	assign req.ready   = (state_q == ST_IDLE) && !(rd_pend_s1 && out_blocked);
	assign rsp.valid   = rsp_v_q;
	assign rsp.bin_db  = rsp_q;

	// ---------------- memories ----------------
	logic [31:0] ring_mem [FFT_N];
	logic [63:0] work_mem [FFT_N];   // real in high word, imag in low word
	logic [15:0] avg_mem  [FFT_N];

	logic        ring_re;
	addr_t       ring_ra;
	logic [31:0] ring_rd_q;
	logic [16:0] win_q;

	logic        wk_we, wk_rea, wk_reb;
	addr_t       wk_wa, wk_raa, wk_rab;
	logic [63:0] wk_wd;
	logic [63:0] wk_rda_q, wk_rdb_q;

	logic               tw_re;
	bfly_t              tw_idx;
	logic signed [31:0] tw_c_q, tw_s_q;

	logic        avg_re, avg_we;
	addr_t       avg_ra, avg_wa;
	logic [15:0] avg_wd;
	logic [15:0] avg_rd_q;

	// ---------------- datapath registers ----------------
	logic signed [33:0] xr_s2, xi_s2;
	logic signed [63:0] bp_rc_q, bp_is_q, bp_ic_q, bp_rs_q;
	logic signed [34:0] tr_q, ti_q;
	logic [63:0]        sq_r_q, sq_i_q;
	logic [63:0]        x_q;
	logic [5:0]         lz_q;
	logic [30:0]        m_q;
	logic [15:0]        frac_q;
	logic signed [49:0] sc_q;
	logic signed [15:0] db_q;
	logic signed [26:0] mix_q;

	// ---------------- butterfly addressing ----------------
	addr_t b10, lowm, bf_u, bf_v, hbit, dst;
	logic  bfly_last, stage_last;
	always_comb begin
		b10        = {1'b0, bfly_q};
		hbit       = addr_t'(1) << stage_q;
		lowm       = hbit - addr_t'(1);
		bf_u       = ((b10 & ~lowm) << 1) | (b10 & lowm);
		bf_v       = bf_u | hbit;
		tw_idx     = (bfly_q & lowm[LOG2N-2:0]) << (stage_t'(LOG2N - 1) - stage_q);
		bfly_last  = (bfly_q == '1);
		stage_last = (stage_q == stage_t'(LOG2N - 1));
		dst        = bin_q ^ addr_t'(HALF_N);   // DC to the middle
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (req_acc && req.opcode == OP_COMPUTE) state_d = ST_LOAD;
			ST_LOAD:     if (ld_n_q[LOG2N] && !ld_v_s1 && !ld_v_s2) state_d = ST_BF_RD;
			ST_BF_RD:    state_d = ST_BF_MUL;
			ST_BF_MUL:   state_d = ST_BF_SUM;
			ST_BF_SUM:   state_d = ST_BF_WU;
			ST_BF_WU:    state_d = ST_BF_WV;
			ST_BF_WV:    state_d = (bfly_last && stage_last) ? ST_DB_RD : ST_BF_RD;
			ST_DB_RD:    state_d = ST_DB_SQ;
			ST_DB_SQ:    state_d = ST_DB_SUM;
			ST_DB_SUM:   state_d = ST_DB_NORM;
			ST_DB_NORM: begin
				if (x_q == '0) state_d = ST_DB_MIX;
				else if (nrm_q == '0) state_d = ST_DB_LOG;
			end
			ST_DB_LOG:   if (lbit_q == '1) state_d = ST_DB_SCALE;
			ST_DB_SCALE: state_d = ST_DB_RND;
			ST_DB_RND:   state_d = ST_DB_MIX;
			ST_DB_MIX:   state_d = ST_DB_WR;
			ST_DB_WR:    state_d = (bin_q == '1) ? ST_IDLE : ST_DB_RD;
		endcase
	end

	// ---------------- memory control ----------------
	logic [8:0]         w_eff;
	logic signed [65:0] mix_rnd;
	always_comb begin
		w_eff   = (wt_q > WT_FULL) ? WT_FULL : wt_q;
		mix_rnd = round_shift(66'(mix_q), 8);

		ring_re = (state_q == ST_LOAD) && !ld_n_q[LOG2N];
		ring_ra = wp_q + ld_n_q[LOG2N-1:0];   // oldest sample first

		wk_we  = 1'b0;
		wk_wa  = bit_rev(ld_n_s2);
		wk_wd  = {32'(round_shift(66'(xr_s2), 15)), 32'(round_shift(66'(xi_s2), 15))};
		wk_rea = 1'b0;
		wk_raa = bf_u;
		wk_reb = 1'b0;
		wk_rab = bf_v;
		tw_re  = 1'b0;
		avg_re = req_acc && (req.opcode == OP_READ);
		avg_ra = req.bin_index;
		avg_we = 1'b0;
		avg_wa = dst;
		avg_wd = started_q ? 16'(mix_rnd) : db_q;

		unique case (state_q)
			ST_LOAD:  wk_we = ld_v_s2;
			ST_BF_RD: begin
				wk_rea = 1'b1;
				wk_reb = 1'b1;
				tw_re  = 1'b1;
			end
			ST_BF_WU: begin
				wk_we = 1'b1;
				wk_wa = bf_u;
				wk_wd = {sat32(36'($signed(wk_rda_q[63:32])) + 36'(tr_q)),
				         sat32(36'($signed(wk_rda_q[31:0])) + 36'(ti_q))};
			end
			ST_BF_WV: begin
				wk_we = 1'b1;
				wk_wa = bf_v;
				wk_wd = {sat32(36'($signed(wk_rda_q[63:32])) - 36'(tr_q)),
				         sat32(36'($signed(wk_rda_q[31:0])) - 36'(ti_q))};
			end
			ST_DB_RD: begin
				wk_rea = 1'b1;
				wk_raa = bin_q;
				avg_re = 1'b1;
				avg_ra = dst;
			end
			ST_DB_WR: avg_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_acc && req.opcode == OP_PUSH) ring_mem[wp_q] <= {req.sample_i, req.sample_q};
		if (ring_re) begin
			ring_rd_q <= ring_mem[ring_ra];
			win_q     <= WIN_ROM[ld_n_q[LOG2N-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (wk_we)  work_mem[wk_wa] <= wk_wd;
		if (wk_rea) wk_rda_q <= work_mem[wk_raa];
		if (wk_reb) wk_rdb_q <= work_mem[wk_rab];
		if (tw_re) begin
			tw_c_q <= TW_COS[tw_idx];
			tw_s_q <= TW_SIN[tw_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (avg_we) avg_mem[avg_wa] <= avg_wd;
		if (avg_re) avg_rd_q <= avg_mem[avg_ra];
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wt_q       <= WT_RESET;
			wp_q       <= '0;
			fill_q     <= '0;
			started_q  <= 1'b0;
			rd_pend_s1 <= 1'b0;
			rsp_v_q    <= 1'b0;
			ld_n_q     <= '0;
			ld_v_s1    <= 1'b0;
			ld_v_s2    <= 1'b0;
			stage_q    <= '0;
			bfly_q     <= '0;
			bin_q      <= '0;
			nrm_q      <= '0;
			lbit_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) wt_q <= cfg_wdata;

			if (req_acc && req.opcode == OP_PUSH) begin
				wp_q <= wp_q + addr_t'(1);
				if (!fill_q[LOG2N]) fill_q <= fill_q + 1'b1;
			end

			// read request: memory data lands in s1, then the output register
			rd_pend_s1 <= (req_acc && req.opcode == OP_READ) || (rd_pend_s1 && out_blocked);
			if (rd_pend_s1 && !out_blocked) rsp_v_q <= 1'b1;
			else if (rsp.ready) rsp_v_q <= 1'b0;

			if (req_acc && req.opcode == OP_COMPUTE) ld_n_q <= '0;
			else if (ring_re) ld_n_q <= ld_n_q + 1'b1;
			ld_v_s1 <= ring_re;
			ld_v_s2 <= ld_v_s1;

			if (state_q == ST_LOAD) begin
				stage_q <= '0;
				bfly_q  <= '0;
			end
			if (state_q == ST_BF_WV) begin
				bfly_q <= bfly_q + bfly_t'(1);
				if (bfly_last) stage_q <= stage_q + stage_t'(1);
			end
			if (state_q == ST_BF_WV && bfly_last && stage_last) bin_q <= '0;
			if (state_q == ST_DB_WR) begin
				bin_q <= bin_q + addr_t'(1);
				if (bin_q == '1) started_q <= 1'b1;
			end

			if (state_q == ST_DB_SUM) nrm_q <= 3'd5;
			else if (state_q == ST_DB_NORM) nrm_q <= nrm_q - 3'd1;
			if (state_q == ST_DB_NORM) lbit_q <= '0;
			else if (state_q == ST_DB_LOG) lbit_q <= lbit_q + 4'd1;
		end
	end

	// ---------------- datapath ----------------
	logic [63:0] nrm_x;
	logic [5:0]  nrm_add;
	logic [61:0] lg_sq;
	logic [21:0] lg;
	logic signed [22:0] lg_d;
	logic signed [65:0] db_rnd;
	always_comb begin
		nrm_x   = x_q;
		nrm_add = '0;
		// one step of a binary leading-zero search
		unique case (nrm_q)
			3'd5: if (x_q[63:32] == '0) begin nrm_x = x_q << 32; nrm_add = 6'd32; end
			3'd4: if (x_q[63:48] == '0) begin nrm_x = x_q << 16; nrm_add = 6'd16; end
			3'd3: if (x_q[63:56] == '0) begin nrm_x = x_q << 8;  nrm_add = 6'd8;  end
			3'd2: if (x_q[63:60] == '0) begin nrm_x = x_q << 4;  nrm_add = 6'd4;  end
			3'd1: if (x_q[63:62] == '0) begin nrm_x = x_q << 2;  nrm_add = 6'd2;  end
			3'd0: if (!x_q[63])         begin nrm_x = x_q << 1;  nrm_add = 6'd1;  end
			default: ;
		endcase
		lg_sq  = 62'(m_q) * 62'(m_q);
		lg     = {6'd63 - lz_q, frac_q};
		lg_d   = $signed({1'b0, lg}) - LG_OFFSET;
		db_rnd = round_shift(66'(sc_q), 32);
	end

	always_ff @(posedge clk) begin
		// load pipeline: window the ring sample, round to the data scale
		ld_n_s1  <= ld_n_q[LOG2N-1:0];
		ld_ok_s1 <= fill_q[LOG2N] || ({1'b0, ring_ra} < fill_q);
		ld_n_s2  <= ld_n_s1;
		xr_s2    <= ld_ok_s1 ? 34'($signed(ring_rd_q[31:16])) * 34'($signed({1'b0, win_q}))
		                     : '0;
		xi_s2    <= ld_ok_s1 ? 34'($signed(ring_rd_q[15:0])) * 34'($signed({1'b0, win_q}))
		                     : '0;

		unique case (state_q)
			ST_BF_MUL: begin
				bp_rc_q <= 64'($signed(wk_rdb_q[63:32])) * 64'(tw_c_q);
				bp_is_q <= 64'($signed(wk_rdb_q[31:0]))  * 64'(tw_s_q);
				bp_ic_q <= 64'($signed(wk_rdb_q[31:0]))  * 64'(tw_c_q);
				bp_rs_q <= 64'($signed(wk_rdb_q[63:32])) * 64'(tw_s_q);
			end
			ST_BF_SUM: begin
				tr_q <= 35'(round_shift(66'(bp_rc_q) + 66'(bp_is_q), 30));
				ti_q <= 35'(round_shift(66'(bp_ic_q) - 66'(bp_rs_q), 30));
			end
			ST_DB_SQ: begin
				sq_r_q <= 64'($signed(wk_rda_q[63:32])) * 64'($signed(wk_rda_q[63:32]));
				sq_i_q <= 64'($signed(wk_rda_q[31:0]))  * 64'($signed(wk_rda_q[31:0]));
			end
			ST_DB_SUM: begin
				x_q  <= sq_r_q + sq_i_q;
				lz_q <= '0;
			end
			ST_DB_NORM: begin
				x_q    <= nrm_x;
				lz_q   <= lz_q + nrm_add;
				m_q    <= nrm_x[63:33];
				frac_q <= '0;
				if (x_q == '0) db_q <= DB_FLOOR;
			end
			ST_DB_LOG: begin
				// square the mantissa; overflow past 2 yields the next fraction bit
				if (lg_sq[61]) begin
					frac_q[~lbit_q] <= 1'b1;
					m_q <= lg_sq[61:31];
				end else begin
					m_q <= lg_sq[60:30];
				end
			end
			ST_DB_SCALE: sc_q <= 50'(lg_d) * 50'(TEN_LOG10_2_Q24);
			ST_DB_RND: begin
				if (db_rnd > 66'sd32767) db_q <= 16'sh7FFF;
				else if (db_rnd < -66'sd32768) db_q <= 16'sh8000;
				else db_q <= 16'(db_rnd);
			end
			ST_DB_MIX: mix_q <= 27'($signed({1'b0, w_eff})) * 27'(db_q)
			                  + 27'($signed({1'b0, WT_FULL - w_eff})) * 27'($signed(avg_rd_q));
			default: ;
		endcase

		if (rd_pend_s1 && !out_blocked) rsp_q <= started_q ? avg_rd_q : DB_FLOOR;
	end

	// ---------------- checks ----------------
	a_load_wr_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		ld_v_s2 |-> state_q == ST_LOAD)
		else $error("load pipeline write outside load phase");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (LOG2N+1)'(FFT_N))
		else $error("fill count beyond ring depth");

	a_last_bin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DB_WR && bin_q == '1) |=> (state_q == ST_IDLE && started_q))
		else $error("spectrum pass did not finish after last bin");

	a_read_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_pend_s1 && !out_blocked) |=> rsp_v_q)
		else $error("pending read not moved to output");

endmodule
